// ----- rtl/skf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the microcode program of the scalar Kalman
// filter core.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Field and register widths
  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 17;
  localparam int VAR_W    = 31;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W    = 56;  // estimate + gain, padded to whole bytes
  localparam int PC_W     = 4;
  localparam int CNT_W    = 4;

  // Unity gain in Q1.16
  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;
  // Saturated variance
  localparam logic [VAR_W-1:0] VAR_MAX = 31'h7FFF_FFFF;

  // Register reset values
  localparam logic [VAR_W-1:0] PROCESS_NOISE_RST     = 31'd1966;
  localparam logic [VAR_W-1:0] MEASUREMENT_NOISE_RST = 31'd6554;
  localparam logic [VAR_W-1:0] INITIAL_VARIANCE_RST  = 31'd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE  = 2'd2;

  // Divider loop: passes of the divider step after its first, one fewer than the trailing quotient bits
  localparam logic [CNT_W-1:0] DIV_LOOP_INIT = 4'd15;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DENOM,
    OP_DIV_HEAD,
    OP_DIV_STEP,
    OP_GAIN,
    OP_MUL_RES,
    OP_UPD_EST,
    OP_MUL_VAR,
    OP_UPD_VAR,
    OP_EMIT
  } op_t;

  // Sequencing conditions
  typedef enum logic [1:0] {
    JMP_NONE,    // fall through
    JMP_NO_REQ,  // stay while no request is offered
    JMP_LOOP,    // jump to target while the loop counter is nonzero
    JMP_BUSY     // stay while the output slot is full, else go to target
  } jmp_t;

  // One microcode word
  typedef struct packed {
    op_t             op;
    jmp_t            cond;
    logic            cnt_ld;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Status back to the sequencer
  typedef struct packed {
    logic req_valid;
    logic out_free;
  } sts_t;

  // Program steps
  localparam logic [PC_W-1:0] PC_ENTRY = 4'd0;
  localparam logic [PC_W-1:0] PC_DIV   = 4'd3;

  // Microcode program
  function automatic ctrl_t ucode_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: JMP_NONE, cnt_ld: 1'b0, target: PC_ENTRY};
    unique case (pc)
      4'd0: w = '{op: OP_LOAD,     cond: JMP_NO_REQ, cnt_ld: 1'b0, target: PC_ENTRY};
      4'd1: w = '{op: OP_DENOM,    cond: JMP_NONE,   cnt_ld: 1'b1, target: PC_ENTRY};
      4'd2: w = '{op: OP_DIV_HEAD, cond: JMP_NONE,   cnt_ld: 1'b0, target: PC_ENTRY};
      4'd3: w = '{op: OP_DIV_STEP, cond: JMP_LOOP,   cnt_ld: 1'b0, target: PC_DIV};
      4'd4: w = '{op: OP_GAIN,     cond: JMP_NONE,   cnt_ld: 1'b0, target: PC_ENTRY};
      4'd5: w = '{op: OP_MUL_RES,  cond: JMP_NONE,   cnt_ld: 1'b0, target: PC_ENTRY};
      4'd6: w = '{op: OP_UPD_EST,  cond: JMP_NONE,   cnt_ld: 1'b0, target: PC_ENTRY};
      4'd7: w = '{op: OP_MUL_VAR,  cond: JMP_NONE,   cnt_ld: 1'b0, target: PC_ENTRY};
      4'd8: w = '{op: OP_UPD_VAR,  cond: JMP_NONE,   cnt_ld: 1'b0, target: PC_ENTRY};
      4'd9: w = '{op: OP_EMIT,     cond: JMP_BUSY,   cnt_ld: 1'b0, target: PC_ENTRY};
      default: w = '{op: OP_NOP,   cond: JMP_NONE,   cnt_ld: 1'b0, target: PC_ENTRY};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/skf_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_sequencer
// Step counter, loop counter and microcode table; issues one control word
// per cycle to the datapath, with its operation suppressed while held.
// ----------------------------------------------------------------------------
module skf_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  skf_pkg::sts_t  sts,
  output skf_pkg::ctrl_t ctrl,
  output logic           entry
);
  import skf_pkg::*;

  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  ctrl_t            word;
  logic             hold;

  // Fetch the current control word
  assign word  = ucode_word(pc);
  assign entry = (word.op == OP_LOAD);

  // Decide the next step; suppress the operation while held
  always_comb begin
    hold     = 1'b0;
    pc_next  = pc + 1'b1;
    cnt_next = cnt;
    unique case (word.cond)
      JMP_NONE: begin
        pc_next = pc + 1'b1;
      end
      JMP_NO_REQ: begin
        hold    = !sts.req_valid;
        pc_next = hold ? pc : pc + 1'b1;
      end
      JMP_LOOP: begin
        if (cnt != '0) begin
          pc_next  = word.target;
          cnt_next = cnt - 1'b1;
        end
      end
      JMP_BUSY: begin
        hold    = !sts.out_free;
        pc_next = hold ? pc : word.target;
      end
      default: begin
        pc_next = PC_ENTRY;
      end
    endcase
    if (word.cnt_ld) begin
      cnt_next = DIV_LOOP_INIT;
    end
    ctrl    = word;
    ctrl.op = hold ? OP_NOP : word.op;
  end

  // Step and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= PC_ENTRY;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

endmodule

// ----- rtl/skf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, configuration registers, restoring divider step, shared
// multiplier and output register, all driven by the microcode op.
// ----------------------------------------------------------------------------
module skf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  skf_pkg::ctrl_t                      ctrl,
  input  logic [skf_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::VAR_W-1:0]           cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [skf_pkg::SAMPLE_W-1:0]        out_estimate,
  output logic [skf_pkg::GAIN_W-1:0]          out_gain,
  output logic                                out_free
);
  import skf_pkg::*;

  // Configuration and filter state
  logic [VAR_W-1:0]           process_noise;
  logic [VAR_W-1:0]           measurement_noise;
  logic [VAR_W-1:0]           variance;
  logic signed [SAMPLE_W-1:0] estimate;

  // Working registers
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [VAR_W-1:0]           p;
  logic [VAR_W:0]             denom;
  logic [VAR_W+1:0]           rem;
  logic [GAIN_W-1:0]          quo;
  logic [GAIN_W-1:0]          gain;
  logic signed [SAMPLE_W:0]   resid;
  logic signed [51:0]         prod;

  // Combinational helpers
  logic [VAR_W:0]             p_sum;
  logic [VAR_W+1:0]           rem_shift;
  logic [VAR_W+1:0]           div_in;
  logic                       div_ge;
  logic signed [33:0]         mul_a;
  logic signed [17:0]         mul_b;
  logic signed [51:0]         mul_p;
  logic signed [35:0]         est_sum;
  logic                       sat_hi;
  logic                       sat_lo;
  logic signed [SAMPLE_W-1:0] est_sat;

  assign out_free = !out_valid || out_ready;

  // Raise the variance by the process noise, saturating
  assign p_sum = {1'b0, variance} + {1'b0, process_noise};

  // Restoring divider step: head compares the remainder, loop shifts first
  assign rem_shift = {rem[VAR_W:0], 1'b0};
  assign div_in    = (ctrl.op == OP_DIV_HEAD) ? rem : rem_shift;
  assign div_ge    = (div_in >= {1'b0, denom});

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_MUL_RES: begin
        mul_a = {resid[SAMPLE_W], resid};
        mul_b = $signed({1'b0, gain});
      end
      OP_MUL_VAR: begin
        mul_a = $signed({3'b000, p});
        mul_b = $signed({1'b0, ONE_Q16 - gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Move the estimate by the floored product, saturating to 32 bits
  assign est_sum = {{4{estimate[SAMPLE_W-1]}}, estimate} + prod[51:16];
  assign sat_hi  = !est_sum[35] && (est_sum[34:31] != 4'h0);
  assign sat_lo  = est_sum[35] && (est_sum[34:31] != 4'hF);
  always_comb begin
    if (sat_hi) begin
      est_sat = 32'sh7FFF_FFFF;
    end else if (sat_lo) begin
      est_sat = 32'sh8000_0000;
    end else begin
      est_sat = est_sum[SAMPLE_W-1:0];
    end
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PROCESS_NOISE_RST;
      measurement_noise <= MEASUREMENT_NOISE_RST;
      variance          <= INITIAL_VARIANCE_RST;
      estimate          <= '0;
      out_valid         <= 1'b0;
    end else begin
      // Register writes; out-of-range indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROCESS_NOISE:     process_noise     <= cfg_data;
          CFG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
          CFG_INITIAL_VARIANCE:  variance          <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.op == OP_UPD_EST) begin
        estimate <= est_sat;
      end
      if (ctrl.op == OP_UPD_VAR) begin
        variance <= prod[46:16];
      end
      // Output slot: load on emit, release when taken
      if (ctrl.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    case (ctrl.op) inside
      OP_LOAD: begin
        sample_q <= sample;
        p        <= p_sum[VAR_W] ? VAR_MAX : p_sum[VAR_W-1:0];
      end
      OP_DENOM: begin
        denom <= {1'b0, p} + {1'b0, measurement_noise};
        rem   <= {2'b00, p};
      end
      OP_DIV_HEAD, OP_DIV_STEP: begin
        rem <= div_ge ? (div_in - {1'b0, denom}) : div_in;
        quo <= (ctrl.op == OP_DIV_HEAD) ? {{(GAIN_W-1){1'b0}}, div_ge}
                                        : {quo[GAIN_W-2:0], div_ge};
      end
      OP_GAIN: begin
        gain  <= (denom == '0) ? '0 : quo;
        resid <= {sample_q[SAMPLE_W-1], sample_q} - {estimate[SAMPLE_W-1], estimate};
      end
      OP_MUL_RES, OP_MUL_VAR: begin
        prod <= mul_p;
      end
      OP_EMIT: begin
        out_estimate <= estimate;
        out_gain     <= gain;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/scalar_kalman_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter: per sample, raise the variance, divide out
// the gain, move the estimate toward the sample and shrink the variance.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  s_tdata[31:0] sample
//  m_*      out  m_tvalid/m_tready  m_tdata[31:0] estimate, [48:32] gain
//  cfg_*    in   cfg_we             cfg_index register, cfg_data value
//
//  Each request occupies the sequencer until its result register loads,
//  and the next request is taken in the following cycle at the earliest.
//  The 17 quotient bits of the restoring gain divider (one a cycle) set
//  most of this; load, setup, the gain step, two multiplies, two updates
//  and the emit step add the rest.
//  A new request is taken once the previous one has reached the output
//  register; the last step stalls while a result still waits there.
//  Reset (rst, synchronous) restores the register defaults, loads the
//  variance with the initial value and clears the estimate.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [31:0] estimate, [48:32] gain, [55:49] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import skf_pkg::*;

  ctrl_t               ctrl;
  sts_t                sts;
  logic                entry;
  logic                out_free;
  logic [SAMPLE_W-1:0] out_estimate;
  logic [GAIN_W-1:0]   out_gain;

  assign sts.req_valid = s_tvalid;
  assign sts.out_free  = out_free;
  assign s_tready      = entry && !rst;
  assign m_tdata       = {{(OUT_W-SAMPLE_W-GAIN_W){1'b0}}, out_gain, out_estimate};

  // Program sequencer
  skf_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .sts   (sts),
    .ctrl  (ctrl),
    .entry (entry)
  );

  // Arithmetic datapath
  skf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .sample       (s_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_estimate (out_estimate),
    .out_gain     (out_gain),
    .out_free     (out_free)
  );

`ifndef SYNTHESIS
  // Leave the entry step right after taking a request
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer stayed at entry after accepting a request");

  // No result can appear in the cycle after an accept
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result emitted too early");

  // Gain never exceeds unity
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48:32] <= ONE_Q16))
    else $error("gain above one");
`endif

endmodule

// ----- verif/tb_scalar_kalman_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter_core
// Self-checking bench for the scalar Kalman filter core. It streams samples
// in and predicts each filter update with its own fixed-point model. Every
// result is compared field by field against that prediction. Directed cases
// cover the field extremes, zero noise, the zero denominator, variance
// saturation and the unused register index. A random part then follows noisy
// sensor tracks under changing noise settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter_core;
  import skf_pkg::*;

  // Expected filter update: estimate and gain
  typedef struct packed {
    logic [SAMPLE_W-1:0] estimate;
    logic [GAIN_W-1:0]   gain;
  } kf_update_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;
  localparam int RAND_PHASE_ITEMS = 75;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [SAMPLE_W-1:0]  s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAR_W-1:0]     cfg_data  = '0;

  // Predictor state and register copies
  logic [VAR_W-1:0]           flt_variance  = INITIAL_VARIANCE_RST;
  logic signed [SAMPLE_W-1:0] flt_estimate  = '0;
  logic [VAR_W-1:0]           reg_proc_noise = PROCESS_NOISE_RST;
  logic [VAR_W-1:0]           reg_meas_noise = MEASUREMENT_NOISE_RST;

  kf_update_t pending_updates[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;

  // Sensor track used by the random stimulus
  int track_q = 0;
  int noise_amp = 16;
  int drift_amp = 4;

  scalar_kalman_filter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [31:0] sample
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [31:0] estimate, [48:32] gain, [55:49] zero
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Stall the result side at the configured rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  // One filter update: predict, correct, shrink the variance
  function automatic kf_update_t filter_step(input logic [SAMPLE_W-1:0] smp);
    longint unsigned p, den, g, nv;
    longint resid, delta, next, g_s;
    kf_update_t upd;
    p = longint'(flt_variance) + longint'(reg_proc_noise);
    if (p > VAR_MAX) p = VAR_MAX;
    den = p + longint'(reg_meas_noise);
    g = (den == 0) ? 0 : (p << 16) / den;
    if (g > ONE_Q16) g = ONE_Q16;
    g_s = g;
    resid = longint'($signed(smp)) - longint'(flt_estimate);
    delta = (resid * g_s) >>> 16;
    next = longint'(flt_estimate) + delta;
    if (next > longint'(32'sh7FFF_FFFF)) next = longint'(32'sh7FFF_FFFF);
    if (next < -longint'(64'h8000_0000)) next = -longint'(64'h8000_0000);
    flt_estimate = next[SAMPLE_W-1:0];
    nv = (p * (longint'(ONE_Q16) - g)) >> 16;
    flt_variance = nv[VAR_W-1:0];
    upd.estimate = flt_estimate;
    upd.gain = g[GAIN_W-1:0];
    return upd;
  endfunction

  // Offer one sample request, with random idle cycles ahead of it
  task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    pending_updates.insert(pending_updates.size(), filter_step(smp));
    samples_sent++;
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register and mirror it in the predictor
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_PROCESS_NOISE:     reg_proc_noise = val;
      CFG_MEASUREMENT_NOISE: reg_meas_noise = val;
      CFG_INITIAL_VARIANCE:  flt_variance = val;
      default: ;
    endcase
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Noise setting drawn from zero, saturation and typical magnitudes
  function automatic logic [VAR_W-1:0] pick_noise();
    logic [VAR_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = VAR_MAX;
      2: v = VAR_W'($urandom_range(0, 65535));
      3: v = VAR_W'($urandom);
      4: v = VAR_W'($urandom_range(0, 1 << 20));
      default: v = VAR_W'($urandom_range(1, 4096));
    endcase
    return v;
  endfunction

  // Mostly a noisy sensor track, some raw words and rail values
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      track_q = track_q + int'($urandom_range(0, 2 * drift_amp)) - drift_amp;
      return SAMPLE_W'(track_q + int'($urandom_range(0, 2 * noise_amp)) - noise_amp);
    end
    if (r < 90) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    kf_update_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
      end else begin
        want = pending_updates.pop_front();
        if (m_tdata[31:0] !== want.estimate)
          report_mismatch("estimate", 64'(m_tdata[31:0]), 64'(want.estimate));
        if (m_tdata[48:32] !== want.gain)
          report_mismatch("gain", 64'(m_tdata[48:32]), 64'(want.gain));
        if (m_tdata[55:49] !== '0)
          report_mismatch("padding", 64'(m_tdata[55:49]), 64'd0);
      end
    end
  end

  // Reset defaults with the sample rails
  task automatic test_reset_defaults();
    push_sample(32'h0001_0000);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'h0000_0000);
    push_sample(32'h0000_0001);
    wait_idle();
  endtask

  // Zero noise: unity gain, then the zero denominator
  task automatic test_zero_noise();
    cfg_write(CFG_PROCESS_NOISE, '0);
    cfg_write(CFG_MEASUREMENT_NOISE, '0);
    push_sample(32'h1234_5678);
    push_sample(32'h0000_0000);
    push_sample(32'h8000_0000);
    wait_idle();
    // Saturated variance with no measurement noise still gives unity gain
    cfg_write(CFG_INITIAL_VARIANCE, VAR_MAX);
    cfg_write(CFG_PROCESS_NOISE, VAR_MAX);
    push_sample(32'hDEAD_BEEF);
    wait_idle();
  endtask

  // All registers at the top of their range
  task automatic test_variance_saturation();
    cfg_write(CFG_PROCESS_NOISE, VAR_MAX);
    cfg_write(CFG_MEASUREMENT_NOISE, VAR_MAX);
    cfg_write(CFG_INITIAL_VARIANCE, VAR_MAX);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h5555_5555);
    push_sample(32'hAAAA_AAAA);
    wait_idle();
  endtask

  // Writes to the unused index must leave every register alone
  task automatic test_unused_index();
    cfg_write(CFG_PROCESS_NOISE, PROCESS_NOISE_RST);
    cfg_write(CFG_MEASUREMENT_NOISE, MEASUREMENT_NOISE_RST);
    cfg_write(CFG_INITIAL_VARIANCE, INITIAL_VARIANCE_RST);
    cfg_write(CFG_UNUSED_INDEX, VAR_MAX);
    push_sample(32'h0002_0000);
    push_sample(32'hFFFE_0000);
    wait_idle();
    cfg_write(CFG_UNUSED_INDEX, '0);
    push_sample(32'h0000_8000);
    wait_idle();
  endtask

  // Random tracks across noise settings and idle patterns
  task automatic test_random_tracks();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        wait_idle();
        cfg_write(CFG_PROCESS_NOISE, pick_noise());
        cfg_write(CFG_MEASUREMENT_NOISE, pick_noise());
        cfg_write(CFG_INITIAL_VARIANCE, pick_noise());
        noise_amp = 1 << $urandom_range(4, 24);
        drift_amp = (noise_amp >> 2) + 1;
        track_q = int'($urandom) >>> $urandom_range(1, 8);
        for (int n = 0; n < RAND_PHASE_ITEMS; n++)
          push_sample(next_sample());
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_noise();
    test_variance_saturation();
    test_unused_index();
    test_random_tracks();
    $display("Covered %0d samples and %0d filter updates over %0d register writes,",
             samples_sent, results_seen, cfg_writes);
    $display("including zero and saturated noise and four idle/stall patterns.");
    if (fail_count == 0) begin
      $display("tb_scalar_kalman_filter_core: PASS");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("tb_scalar_kalman_filter_core: FAIL");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still outstanding", pending_updates.size());
    $display("tb_scalar_kalman_filter_core: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/skf_pkg.sv
rtl/skf_sequencer.sv
rtl/skf_datapath.sv
rtl/scalar_kalman_filter_core.sv
verif/tb_scalar_kalman_filter_core.sv
